FILE: sv/s5udp_pkg.sv
// ----------------------------------------------------------------------------
// s5udp_pkg: shared types and constants of the SOCKS5 UDP header parser
// Field widths, address type codes, status and result codes, parse phases.
// ----------------------------------------------------------------------------
package s5udp_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned AddrW   = 64;
  localparam int unsigned PortW   = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 9;

  // address type codes
  localparam logic [ByteW-1:0] AtypIpv4   = 8'd1;
  localparam logic [ByteW-1:0] AtypDomain = 8'd3;
  localparam logic [ByteW-1:0] AtypIpv6   = 8'd4;

  // address byte counts and position of the type byte
  localparam logic [ByteW-1:0] Ipv4Bytes   = 8'd4;
  localparam logic [ByteW-1:0] Ipv6Bytes   = 8'd16;
  localparam logic [PosW-1:0]  TypePosition = 9'd3;

  // result kinds
  localparam logic KindNameByte = 1'b0;
  localparam logic KindSummary  = 1'b1;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    StatusOk        = 2'd0,
    StatusTooShort  = 2'd1,
    StatusBadAtyp   = 2'd2,
    StatusReserved  = 2'd3
  } status_e;

  // parse phases, one-hot
  typedef enum logic [5:0] {
    PhFixed = 6'b000001,
    PhAddr  = 6'b000010,
    PhNlen  = 6'b000100,
    PhName  = 6'b001000,
    PhPortH = 6'b010000,
    PhPortL = 6'b100000
  } phase_e;

  // one result transaction
  typedef struct packed {
    logic               result_kind;
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   addr_type;
    logic [AddrW-1:0]   address_high;
    logic [AddrW-1:0]   address_low;
    logic [PortW-1:0]   port;
    logic [ByteW-1:0]   name_byte;
    logic [ByteW-1:0]   name_length;
    logic [PosW-1:0]    header_length;
  } result_t;

endpackage

FILE: sv/s5udp_if.sv
// ----------------------------------------------------------------------------
// s5udp_if: byte and result channels of the SOCKS5 UDP header parser
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface s5udp_byte_if;
  logic                           valid;
  logic                           ready;
  logic [s5udp_pkg::ByteW-1:0]    data_byte;
  logic                           last_of_datagram;

  modport source (output valid, output data_byte, output last_of_datagram, input ready);
  modport sink   (input valid, input data_byte, input last_of_datagram, output ready);
endinterface

interface s5udp_result_if;
  logic                           valid;
  logic                           ready;
  logic                           result_kind;
  logic [s5udp_pkg::StatusW-1:0]  status;
  logic [s5udp_pkg::ByteW-1:0]    addr_type;
  logic [s5udp_pkg::AddrW-1:0]    address_high;
  logic [s5udp_pkg::AddrW-1:0]    address_low;
  logic [s5udp_pkg::PortW-1:0]    port;
  logic [s5udp_pkg::ByteW-1:0]    name_byte;
  logic [s5udp_pkg::ByteW-1:0]    name_length;
  logic [s5udp_pkg::PosW-1:0]     header_length;

  modport source (output valid, output result_kind, output status, output addr_type,
                  output address_high, output address_low, output port,
                  output name_byte, output name_length, output header_length,
                  input ready);
  modport sink   (input valid, input result_kind, input status, input addr_type,
                  input address_high, input address_low, input port,
                  input name_byte, input name_length, input header_length,
                  output ready);
endinterface

FILE: sv/socks5_udp_header_parser_core.sv
// ----------------------------------------------------------------------------
// socks5_udp_header_parser_core: SOCKS5 UDP relay header parser
// Parses one datagram byte per transaction and reports name bytes, a header
// summary, or an error.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one datagram byte per transaction, last_of_datagram marking
//         the final byte. out_o carries at most one result per input byte:
//         a domain name byte (result_kind 0) or a summary/error (kind 1).
//   Output: a result is registered; it is valid in the cycle after its byte is accepted.
//   Throughput: one byte per cycle unless the output stalls; the phase update for a byte is a single
//         pass of logic between the parse state and the result register.
//   Stall: the result register is the only buffer. in_i.ready is high while
//         that register is empty or being taken in the same cycle; while the
//         receiver holds off, input stalls and no state changes.
//   A header that ends early yields a too-short error on the last byte; name
//         bytes already sent for that datagram are then void. An unknown type
//         yields an error on the type byte, and the rest is dropped.
//   Reset: parser returns to the fixed header phase, no result pending.
//         The parser state also returns to that point after each last byte.
// ----------------------------------------------------------------------------
module socks5_udp_header_parser_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  s5udp_byte_if.sink            in_i,
  s5udp_result_if.source        out_o
);

  // parse state
  s5udp_pkg::phase_e                 phase_q, phase_d;
  logic [s5udp_pkg::PosW-1:0]        pos_q, pos_d;
  logic [s5udp_pkg::ByteW-1:0]       atyp_q, atyp_d;
  logic [2*s5udp_pkg::AddrW-1:0]     addr_q, addr_d;
  logic [s5udp_pkg::ByteW-1:0]       nlen_q, nlen_d;
  logic [s5udp_pkg::ByteW-1:0]       left_q, left_d;
  logic [s5udp_pkg::PortW-1:0]       port_q, port_d;
  logic                              skip_q, skip_d;

  // result register
  s5udp_pkg::result_t                res_q, res_d;
  logic                              res_vld_q, res_vld_d;
  logic                              accept;
  logic [s5udp_pkg::ByteW-1:0]       b;
  logic [s5udp_pkg::ByteW-1:0]       left_dec;

  assign in_i.ready = !res_vld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;
  assign left_dec   = left_q - 8'd1;

  // phase update and result formation for one byte
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    atyp_d    = atyp_q;
    addr_d    = addr_q;
    nlen_d    = nlen_q;
    left_d    = left_q;
    port_d    = port_q;
    skip_d    = skip_q;
    res_d     = '0;
    res_vld_d = res_vld_q && !out_o.ready;

    if (accept) begin
      res_vld_d = 1'b0;
      if (!skip_q) begin
        unique case (phase_q)
          s5udp_pkg::PhFixed: begin
            if (pos_q == s5udp_pkg::TypePosition) begin
              atyp_d = b;
              if (b == s5udp_pkg::AtypIpv4) begin
                left_d  = s5udp_pkg::Ipv4Bytes;
                phase_d = s5udp_pkg::PhAddr;
              end else if (b == s5udp_pkg::AtypIpv6) begin
                left_d  = s5udp_pkg::Ipv6Bytes;
                phase_d = s5udp_pkg::PhAddr;
              end else if (b == s5udp_pkg::AtypDomain) begin
                phase_d = s5udp_pkg::PhNlen;
              end else begin
                res_d.result_kind  = s5udp_pkg::KindSummary;
                res_d.status       = s5udp_pkg::StatusBadAtyp;
                res_d.addr_type    = b;
                res_vld_d          = 1'b1;
                skip_d             = 1'b1;
              end
            end
          end
          s5udp_pkg::PhAddr: begin
            addr_d = {addr_q[2*s5udp_pkg::AddrW-s5udp_pkg::ByteW-1:0], b};
            left_d = left_dec;
            if (left_dec == '0) begin
              phase_d = s5udp_pkg::PhPortH;
            end
          end
          s5udp_pkg::PhNlen: begin
            nlen_d  = b;
            left_d  = b;
            phase_d = (b != '0) ? s5udp_pkg::PhName : s5udp_pkg::PhPortH;
          end
          s5udp_pkg::PhName: begin
            res_d.result_kind  = s5udp_pkg::KindNameByte;
            res_d.status       = s5udp_pkg::StatusOk;
            res_d.addr_type    = atyp_q;
            res_d.name_byte    = b;
            res_d.name_length  = nlen_q;
            res_vld_d          = 1'b1;
            left_d             = left_dec;
            if (left_dec == '0) begin
              phase_d = s5udp_pkg::PhPortH;
            end
          end
          s5udp_pkg::PhPortH: begin
            port_d  = {b, port_q[s5udp_pkg::ByteW-1:0]};
            phase_d = s5udp_pkg::PhPortL;
          end
          s5udp_pkg::PhPortL: begin
            port_d              = {port_q[s5udp_pkg::PortW-1:s5udp_pkg::ByteW], b};
            res_d.result_kind   = s5udp_pkg::KindSummary;
            res_d.status        = s5udp_pkg::StatusOk;
            res_d.addr_type     = atyp_q;
            res_d.address_high  = addr_q[2*s5udp_pkg::AddrW-1:s5udp_pkg::AddrW];
            res_d.address_low   = addr_q[s5udp_pkg::AddrW-1:0];
            res_d.port          = {port_q[s5udp_pkg::PortW-1:s5udp_pkg::ByteW], b};
            res_d.name_length   = nlen_q;
            res_d.header_length = pos_q + 9'd1;
            res_vld_d           = 1'b1;
            skip_d              = 1'b1;
          end
          default: begin
            skip_d = 1'b1;
          end
        endcase
        pos_d = pos_q + 9'd1;
      end

      // end of datagram: too-short error if header incomplete, then restart
      if (in_i.last_of_datagram) begin
        if (!skip_d) begin
          res_d              = '0;
          res_d.result_kind  = s5udp_pkg::KindSummary;
          res_d.status       = s5udp_pkg::StatusTooShort;
          res_d.addr_type    = atyp_d;
          res_vld_d          = 1'b1;
        end
        phase_d = s5udp_pkg::PhFixed;
        pos_d   = '0;
        atyp_d  = '0;
        addr_d  = '0;
        nlen_d  = '0;
        left_d  = '0;
        port_d  = '0;
        skip_d  = 1'b0;
      end
    end
  end

  // control and parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= s5udp_pkg::PhFixed;
      pos_q     <= '0;
      atyp_q    <= '0;
      addr_q    <= '0;
      nlen_q    <= '0;
      left_q    <= '0;
      port_q    <= '0;
      skip_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      atyp_q    <= atyp_d;
      addr_q    <= addr_d;
      nlen_q    <= nlen_d;
      left_q    <= left_d;
      port_q    <= port_d;
      skip_q    <= skip_d;
      res_vld_q <= res_vld_d;
    end
  end

  // result payload, loaded with each accepted byte
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  // output channel
  assign out_o.valid         = res_vld_q;
  assign out_o.result_kind   = res_q.result_kind;
  assign out_o.status        = res_q.status;
  assign out_o.addr_type     = res_q.addr_type;
  assign out_o.address_high  = res_q.address_high;
  assign out_o.address_low   = res_q.address_low;
  assign out_o.port          = res_q.port;
  assign out_o.name_byte     = res_q.name_byte;
  assign out_o.name_length   = res_q.name_length;
  assign out_o.header_length = res_q.header_length;

endmodule
